// ===== design/vao_pkg.sv =====
`timescale 1ns / 1ps
package vao_pkg;

  localparam int CORDIC_STEPS     = 28;
  localparam int TABLE_SCALE_BITS = 24;
  localparam int NORM_BITS        = 30;
  localparam int CORDIC_W         = 34;
  localparam int OUT_BITS         = 16;

  localparam logic signed [CORDIC_W-1:0] Z_QUARTER = 34'sd1509949440;
  localparam logic signed [CORDIC_W-1:0] Z_HALF    = 34'sd3019898880;

  // Control that travels with each pipeline slot.
  typedef struct packed {
    logic valid;
    logic degen;
    logic quad;
  } vao_ctl_t;

  // Arctangent of 2^-i in degrees scaled by 2^24.
  function automatic logic signed [CORDIC_W-1:0] atan_deg(input int i);
    logic signed [CORDIC_W-1:0] v;
    case (i)
      0:  v = 34'sd754974720;
      1:  v = 34'sd445687602;
      2:  v = 34'sd235489088;
      3:  v = 34'sd119537938;
      4:  v = 34'sd60000934;
      5:  v = 34'sd30029717;
      6:  v = 34'sd15018523;
      7:  v = 34'sd7509720;
      8:  v = 34'sd3754917;
      9:  v = 34'sd1877466;
      10: v = 34'sd938734;
      11: v = 34'sd469367;
      12: v = 34'sd234684;
      13: v = 34'sd117342;
      14: v = 34'sd58671;
      15: v = 34'sd29335;
      16: v = 34'sd14668;
      17: v = 34'sd7334;
      18: v = 34'sd3667;
      19: v = 34'sd1833;
      20: v = 34'sd917;
      21: v = 34'sd458;
      22: v = 34'sd229;
      23: v = 34'sd115;
      24: v = 34'sd57;
      25: v = 34'sd29;
      26: v = 34'sd14;
      27: v = 34'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/vao_pts_if.sv =====
`timescale 1ns / 1ps
interface vao_pts_if #(parameter int COORD_BITS = 14);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] second_x;
  logic signed [COORD_BITS-1:0] second_y;
  logic signed [COORD_BITS-1:0] ref_x;
  logic signed [COORD_BITS-1:0] ref_y;

  modport source (output valid, first_x, first_y, second_x, second_y, ref_x, ref_y,
                  input ready);
  modport sink (input valid, first_x, first_y, second_x, second_y, ref_x, ref_y,
                output ready);
endinterface

// ===== design/vao_res_if.sv =====
`timescale 1ns / 1ps
interface vao_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] angle_deg;
  logic        degenerate;

  modport source (output valid, angle_deg, degenerate, input ready);
  modport sink (input valid, angle_deg, degenerate, output ready);
endinterface

// ===== design/vao_front.sv =====
`timescale 1ns / 1ps
module vao_front #(
  parameter int COORD_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  logic signed [COORD_BITS-1:0]  p1x,
  input  logic signed [COORD_BITS-1:0]  p1y,
  input  logic signed [COORD_BITS-1:0]  p2x,
  input  logic signed [COORD_BITS-1:0]  p2y,
  input  logic signed [COORD_BITS-1:0]  cx,
  input  logic signed [COORD_BITS-1:0]  cy,
  output vao_pkg::vao_ctl_t             ctl,
  output logic signed [2*COORD_BITS+2:0] dot,
  output logic signed [2*COORD_BITS+2:0] crs
);
  import vao_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic v1, v2, v3, v4;
  logic signed [COORD_BITS-1:0] a1x, a1y, a2x, a2y, acx, acy;
  logic signed [COORD_BITS-1:0] b1x, b1y, b2x, b2y, bcx, bcy;
  logic signed [DW-1:0] e1x, e1y, e2x, e2y;
  logic signed [PW-1:0] s1x, s1y, s2x, s2y;
  logic signed [DW-1:0] px, py, qx, qy;
  logic d3, d4;
  logic signed [PW-1:0] mxx, myy, mxy, myx;

  logic signed [PW:0] d1, d2;
  logic signed [COORD_BITS-1:0] ax, ay, bx, by;
  logic signed [DW-1:0] px_next, py_next, qx_next, qy_next;

  always_comb begin
    d1 = {s1x[PW-1], s1x} + {s1y[PW-1], s1y};
    d2 = {s2x[PW-1], s2x} + {s2y[PW-1], s2y};
    if (d1 < d2) begin
      bx = b1x; by = b1y; ax = b2x; ay = b2y;
    end else begin
      bx = b2x; by = b2y; ax = b1x; ay = b1y;
    end
    px_next = DW'(bx) - DW'(ax);
    py_next = DW'(by) - DW'(ay);
    qx_next = DW'(bcx) - DW'(ax);
    qy_next = DW'(bcy) - DW'(ay);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      ctl <= '0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      ctl <= '{valid: v4, degen: d4, quad: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1x <= p1x; a1y <= p1y; a2x <= p2x; a2y <= p2y; acx <= cx; acy <= cy;
      e1x <= DW'(p1x) - DW'(cx);
      e1y <= DW'(p1y) - DW'(cy);
      e2x <= DW'(p2x) - DW'(cx);
      e2y <= DW'(p2y) - DW'(cy);
      b1x <= a1x; b1y <= a1y; b2x <= a2x; b2y <= a2y; bcx <= acx; bcy <= acy;
      s1x <= e1x * e1x;
      s1y <= e1y * e1y;
      s2x <= e2x * e2x;
      s2y <= e2y * e2y;
      px <= px_next; py <= py_next; qx <= qx_next; qy <= qy_next;
      d3 <= ((px_next == '0) && (py_next == '0)) || ((qx_next == '0) && (qy_next == '0));
      mxx <= px * qx;
      myy <= py * qy;
      mxy <= px * qy;
      myx <= py * qx;
      d4 <= d3;
      dot <= {mxx[PW-1], mxx} + {myy[PW-1], myy};
      crs <= {mxy[PW-1], mxy} - {myx[PW-1], myx};
    end
  end

endmodule

// ===== design/vao_norm.sv =====
`timescale 1ns / 1ps
module vao_norm #(
  parameter int COORD_BITS = 14
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           adv,
  input  vao_pkg::vao_ctl_t              in_ctl,
  input  logic signed [2*COORD_BITS+2:0] dot,
  input  logic signed [2*COORD_BITS+2:0] crs,
  output vao_pkg::vao_ctl_t              ctl,
  output logic [vao_pkg::NORM_BITS-1:0]  xn,
  output logic [vao_pkg::NORM_BITS-1:0]  yn
);
  import vao_pkg::*;

  localparam int MW = 2 * COORD_BITS + 2;
  localparam int PB = $clog2(MW);
  localparam int EW = MW + NORM_BITS;

  vao_ctl_t c1, c2;
  logic [MW-1:0] x1, y1, x2, y2;
  logic [PB-1:0] msb;

  logic signed [2*COORD_BITS+2:0] crs_abs, dot_neg;
  logic [MW-1:0] both;
  logic [PB-1:0] msb_next;
  logic [EW-1:0] xe, ye;

  always_comb begin
    crs_abs = crs[2*COORD_BITS+2] ? -crs : crs;
    dot_neg = -dot;
    both = x1 | y1;
    msb_next = '0;
    for (int i = 0; i < MW; i++) begin
      if (both[i]) msb_next = PB'(i);
    end
    xe = {x2, {NORM_BITS{1'b0}}} >> ({1'b0, msb} + 1'b1);
    ye = {y2, {NORM_BITS{1'b0}}} >> ({1'b0, msb} + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0; c2 <= '0; ctl <= '0;
    end else if (adv) begin
      c1 <= '{valid: in_ctl.valid, degen: in_ctl.degen, quad: dot[2*COORD_BITS+2]};
      c2 <= c1;
      ctl <= c2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (dot[2*COORD_BITS+2]) begin
        x1 <= crs_abs[MW-1:0];
        y1 <= dot_neg[MW-1:0];
      end else begin
        x1 <= dot[MW-1:0];
        y1 <= crs_abs[MW-1:0];
      end
      x2 <= x1; y2 <= y1;
      msb <= msb_next;
      xn <= xe[NORM_BITS-1:0];
      yn <= ye[NORM_BITS-1:0];
    end
  end

endmodule

// ===== design/vao_cordic.sv =====
`timescale 1ns / 1ps
module vao_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  vao_pkg::vao_ctl_t                   in_ctl,
  input  logic [vao_pkg::NORM_BITS-1:0]       xn,
  input  logic [vao_pkg::NORM_BITS-1:0]       yn,
  output vao_pkg::vao_ctl_t                   ctl,
  output logic signed [vao_pkg::CORDIC_W-1:0] z
);
  import vao_pkg::*;

  vao_ctl_t                   c [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] x [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] y [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] a [0:CORDIC_STEPS];

  assign c[0] = in_ctl;
  assign x[0] = CORDIC_W'({1'b0, xn});
  assign y[0] = CORDIC_W'({1'b0, yn});
  assign a[0] = in_ctl.quad ? Z_QUARTER : '0;

  // One micro-rotation per register stage; the shift per stage is fixed.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        c[i+1] <= '0;
      end else if (adv) begin
        c[i+1] <= c[i];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (y[i] > 0) begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          a[i+1] <= a[i] + atan_deg(i);
        end else begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          a[i+1] <= a[i] - atan_deg(i);
        end
      end
    end
  end

  assign ctl = c[CORDIC_STEPS];
  assign z   = a[CORDIC_STEPS];

endmodule

// ===== design/vertex_angle_of_three_points.sv =====
`timescale 1ns / 1ps
// Vertex angle of three points. Each transfer on pts carries two points P1, P2 and a
// reference point C; of P1 and P2 the one nearer to C by squared distance is B (P2 on a
// tie) and the other is A. The block returns the angle at A between A->B and A->C in
// degrees, unsigned with ANGLE_FRAC_BITS fraction bits, computed as atan2(|cross|, dot)
// by a 28-step CORDIC, which equals the clamped acos of the normalized dot product.
// When either vector has zero length, degenerate is 1 and angle_deg is 0. The block
// accepts one transfer per cycle while no result waits on res and produces one result
// per input, in order. It has five stages of differences, squares, selection, products
// and sums, three of normalization, one per CORDIC step, and the output register. The
// whole pipeline holds while a result waits on res, so nothing is lost or repeated.
module vertex_angle_of_three_points #(
  parameter int COORD_BITS      = 14,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input logic clk,
  input logic rst,
  vao_pts_if.sink   pts,
  vao_res_if.source res
);
  import vao_pkg::*;

  localparam int SH = TABLE_SCALE_BITS - ANGLE_FRAC_BITS;
  localparam logic [CORDIC_W-1:0] R_MAX = CORDIC_W'(180) << ANGLE_FRAC_BITS;
  localparam logic [CORDIC_W-1:0] HALF  = CORDIC_W'(1) << (SH - 1);

  // Every stage moves together; the pipeline advances unless a result is held.
  logic adv;
  assign adv       = !res.valid || res.ready;
  assign pts.ready = adv;

  vao_ctl_t f_ctl, n_ctl, k_ctl;
  logic signed [2*COORD_BITS+2:0] dot, crs;
  logic [NORM_BITS-1:0] xn, yn;
  logic signed [CORDIC_W-1:0] z;

  vao_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(pts.valid),
    .p1x(pts.first_x), .p1y(pts.first_y), .p2x(pts.second_x), .p2y(pts.second_y),
    .cx(pts.ref_x), .cy(pts.ref_y), .ctl(f_ctl), .dot(dot), .crs(crs)
  );

  vao_norm #(.COORD_BITS(COORD_BITS)) u_norm (
    .clk(clk), .rst(rst), .adv(adv), .in_ctl(f_ctl), .dot(dot), .crs(crs),
    .ctl(n_ctl), .xn(xn), .yn(yn)
  );

  vao_cordic u_cordic (
    .clk(clk), .rst(rst), .adv(adv), .in_ctl(n_ctl), .xn(xn), .yn(yn),
    .ctl(k_ctl), .z(z)
  );

  // Clamp the accumulated angle to [0, 180] degrees, then round half up.
  logic [CORDIC_W-1:0] zc, r, r_sat;
  always_comb begin
    if (z < 0) begin
      zc = '0;
    end else if (z > Z_HALF) begin
      zc = Z_HALF;
    end else begin
      zc = z;
    end
    r = (zc + HALF) >> SH;
    r_sat = (r > R_MAX) ? R_MAX : r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (adv) begin
      res.valid <= k_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.degenerate <= k_ctl.degen;
      res.angle_deg  <= k_ctl.degen ? '0 : r_sat[OUT_BITS-1:0];
    end
  end

endmodule
